/* sv/khtf_pkg.sv */
package khtf_pkg;

  localparam int NUM_KEYS  = 256;
  localparam int TOP_COUNT = 5;
  localparam int N_OUT     = (TOP_COUNT < NUM_KEYS) ? TOP_COUNT : NUM_KEYS;
  localparam int KEY_W     = $clog2(NUM_KEYS);
  localparam int RANK_W    = $clog2(N_OUT + 1);
  localparam int CNT_W     = 32;

  localparam logic CFG_KEY_EVENT_TYPE = 1'b0;
  localparam logic CFG_WATCHED_KEY    = 1'b1;

  localparam logic CMD_EVENT  = 1'b0;
  localparam logic CMD_REPORT = 1'b1;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_EV_WR = 6'b000010,
    ST_W_LAT = 6'b000100,
    ST_SCAN  = 6'b001000,
    ST_DRAIN = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  typedef struct packed {
    logic             start;
    logic             next;
    logic             cand_v;
    logic [CNT_W-1:0] cand_cnt;
    logic [KEY_W-1:0] cand_key;
  } sel_ctrl_t;

  typedef struct packed {
    logic             found;
    logic [CNT_W-1:0] best_cnt;
    logic [KEY_W-1:0] best_key;
  } sel_stat_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == '1) ? v : v + CNT_W'(1);
  endfunction

endpackage

/* sv/khtf_ram.sv */
module khtf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/khtf_sel.sv */
module khtf_sel
  import khtf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  sel_ctrl_t ctrl,
  output sel_stat_t stat
);

  logic             found_r;
  logic             has_prev_r;
  logic [CNT_W-1:0] best_cnt_r;
  logic [KEY_W-1:0] best_key_r;
  logic [CNT_W-1:0] prev_cnt_r;
  logic [KEY_W-1:0] prev_key_r;
  logic             elig;
  logic             take;

  // candidate must rank strictly after the previous pick (count desc, key asc)
  assign elig = !has_prev_r || (ctrl.cand_cnt < prev_cnt_r) ||
                ((ctrl.cand_cnt == prev_cnt_r) && (ctrl.cand_key > prev_key_r));
  assign take = ctrl.cand_v && elig && (!found_r || (ctrl.cand_cnt > best_cnt_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r    <= 1'b0;
      has_prev_r <= 1'b0;
    end else if (ctrl.start) begin
      found_r    <= 1'b0;
      has_prev_r <= 1'b0;
    end else if (ctrl.next) begin
      found_r    <= 1'b0;
      has_prev_r <= 1'b1;
    end else if (take) begin
      found_r    <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.next) begin
      prev_cnt_r <= best_cnt_r;
      prev_key_r <= best_key_r;
    end
    if (take && !ctrl.start && !ctrl.next) begin
      best_cnt_r <= ctrl.cand_cnt;
      best_key_r <= ctrl.cand_key;
    end
  end

  assign stat.found    = found_r;
  assign stat.best_cnt = best_cnt_r;
  assign stat.best_key = best_key_r;

endmodule

/* sv/key_histogram_top_five.sv */
// channel | dir | handshake              | payload
// in      | in  | in_tvalid / in_tready  | tuser: command; tdata: type, value, key code
// out     | out | out_tvalid / out_tready| tdata: rank, key, counts; tlast: last of report
// cfg     | in  | cfg_we                 | cfg_addr: register index; cfg_wdata: value
//
// Event: a counted one reads the counter RAM, then does a saturating write-back.
// Report: one compare unit scans every counter once per rank; each rank's result then
// waits until the result register is free of out_tready back-pressure.
// Reset is synchronous; counters read as zero until first written (per-key valid bits).
// in_tready is high only between items; a waiting result does not block the next item.
module key_histogram_top_five
  import khtf_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // event_type[15:0], event_value[47:16], key_code[63:48]
  input  logic         in_tuser,   // command
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [111:0] out_tdata,  // rank[2:0], reported_key[10:3], key_count[42:11],
                                   // total_count[74:43], watched_count[106:75], zero pad
  output logic         out_tlast,
  input  logic         cfg_we,
  input  logic         cfg_addr,
  input  logic [15:0]  cfg_wdata
);

  state_t            state_r, state_nxt;
  logic [15:0]       kev_type_r;
  logic [7:0]        wkey_r;
  logic [CNT_W-1:0]  total_r, total_nxt;
  logic [NUM_KEYS-1:0] vld_r;
  logic              rd_vld_r;
  logic [KEY_W-1:0]  evt_addr_r;
  logic              wok_r;
  logic [CNT_W-1:0]  watched_r;
  logic [KEY_W-1:0]  scan_r, scan_nxt;
  logic              cand_v_r;
  logic [KEY_W-1:0]  cand_key_r;
  logic [RANK_W-1:0] rank_r, rank_nxt;
  logic              out_valid_r;
  logic [2:0]        out_rank_r;
  logic [7:0]        out_key_r;
  logic [CNT_W-1:0]  out_kcnt_r;
  logic [CNT_W-1:0]  out_total_r;
  logic [CNT_W-1:0]  out_watch_r;
  logic              out_last_r;

  logic [15:0]       ev_type;
  logic [31:0]       ev_value;
  logic [15:0]       ev_code;
  logic              in_xfer;
  logic              ev_hit;
  logic              out_free;
  logic              load_out;
  logic              rank_last;
  logic [KEY_W-1:0]  rd_addr;
  logic [CNT_W-1:0]  ram_q;
  logic [CNT_W-1:0]  rd_cnt;
  logic              ram_we;
  sel_ctrl_t         sel_ctl;
  sel_stat_t         sel_st;

  assign ev_type  = in_tdata[15:0];
  assign ev_value = in_tdata[47:16];
  assign ev_code  = in_tdata[63:48];

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign ev_hit    = (ev_type == kev_type_r) && (ev_value == 32'd0) &&
                     (32'(ev_code) < 32'(NUM_KEYS));
  assign out_free  = !out_valid_r || out_tready;
  assign load_out  = (state_r == ST_EMIT) && out_free;
  assign rank_last = (rank_r == RANK_W'(N_OUT - 1));
  assign rd_cnt    = rd_vld_r ? ram_q : '0;
  assign ram_we    = (state_r == ST_EV_WR);

  always_comb begin
    case (state_r)
      ST_IDLE: rd_addr = (in_tuser == CMD_REPORT) ? KEY_W'(wkey_r) : KEY_W'(ev_code);
      ST_SCAN: rd_addr = scan_r;
      default: rd_addr = '0;
    endcase
  end

  khtf_ram #(
    .WIDTH(CNT_W),
    .DEPTH(NUM_KEYS)
  ) u_cnt_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(evt_addr_r),
    .wdata(sat_inc(rd_cnt)),
    .raddr(rd_addr),
    .rdata(ram_q)
  );

  assign sel_ctl.start    = (state_r == ST_W_LAT);
  assign sel_ctl.next     = load_out;
  assign sel_ctl.cand_v   = cand_v_r;
  assign sel_ctl.cand_cnt = rd_cnt;
  assign sel_ctl.cand_key = cand_key_r;

  khtf_sel u_sel (
    .clk  (clk),
    .rst_n(rst_n),
    .ctrl (sel_ctl),
    .stat (sel_st)
  );

  always_comb begin
    state_nxt = state_r;
    scan_nxt  = scan_r;
    rank_nxt  = rank_r;
    total_nxt = total_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_tuser == CMD_REPORT) begin
            state_nxt = ST_W_LAT;
          end else if (ev_hit) begin
            state_nxt = ST_EV_WR;
          end
        end
      end
      ST_EV_WR: begin
        total_nxt = sat_inc(total_r);
        state_nxt = ST_IDLE;
      end
      ST_W_LAT: begin
        scan_nxt  = '0;
        rank_nxt  = '0;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_r == KEY_W'(NUM_KEYS - 1)) begin
          state_nxt = ST_DRAIN;
        end else begin
          scan_nxt = scan_r + KEY_W'(1);
        end
      end
      ST_DRAIN: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          if (rank_last) begin
            state_nxt = ST_IDLE;
          end else begin
            rank_nxt  = rank_r + RANK_W'(1);
            scan_nxt  = '0;
            state_nxt = ST_SCAN;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      kev_type_r  <= 16'd1;
      wkey_r      <= 8'd56;
      total_r     <= '0;
      vld_r       <= '0;
      rd_vld_r    <= 1'b0;
      cand_v_r    <= 1'b0;
      rank_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      total_r  <= total_nxt;
      rank_r   <= rank_nxt;
      rd_vld_r <= vld_r[rd_addr];
      cand_v_r <= (state_r == ST_SCAN);
      if (ram_we) begin
        vld_r[evt_addr_r] <= 1'b1;
      end
      if (cfg_we) begin
        case (cfg_addr)
          CFG_KEY_EVENT_TYPE: kev_type_r <= cfg_wdata;
          CFG_WATCHED_KEY:    wkey_r     <= cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_r     <= scan_nxt;
    cand_key_r <= scan_r;
    if (in_xfer) begin
      evt_addr_r <= KEY_W'(ev_code);
      wok_r      <= (32'(wkey_r) < 32'(NUM_KEYS));
    end
    if (state_r == ST_W_LAT) begin
      watched_r <= wok_r ? rd_cnt : '0;
    end
    if (load_out) begin
      out_rank_r  <= 3'(rank_r);
      out_key_r   <= 8'(sel_st.best_key);
      out_kcnt_r  <= sel_st.best_cnt;
      out_total_r <= total_r;
      out_watch_r <= watched_r;
      out_last_r  <= rank_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {5'd0, out_watch_r, out_total_r, out_kcnt_r, out_key_r, out_rank_r};

`ifndef SYNTHESIS
  a_total_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (total_r >= $past(total_r)))
    else $error("total counter decreased");

  a_emit_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> sel_st.found)
    else $error("rank pass ended without a pick");

  a_descending: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && (rank_r != '0)) |-> (sel_st.best_cnt <= out_kcnt_r))
    else $error("report counts not descending");

  a_last_rank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata[2:0] == 3'(N_OUT - 1)))
    else $error("last flag on wrong rank");
`endif

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import khtf_pkg::*;

  localparam int SETTLE_CYCLES  = 20;
  localparam int TAIL_CYCLES    = 1500;
  localparam int HOLD_CYCLES    = 2500;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [KEY_W-1:0]  key;
    logic [CNT_W-1:0]  key_count;
    logic [CNT_W-1:0]  total_count;
    logic [CNT_W-1:0]  watched_count;
    logic              last;
  } report_row_t;

  logic         clk = 1'b0;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [63:0]  in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [111:0] out_tdata;
  logic         out_tlast;
  logic         cfg_we;
  logic         cfg_addr;
  logic [15:0]  cfg_wdata;

  // histogram shadow
  logic [CNT_W-1:0] key_hits [NUM_KEYS];
  logic [CNT_W-1:0] release_total;
  logic [15:0]      key_type_sel;
  logic [7:0]       watched_sel;
  report_row_t      report_rows_q[$];

  int err_count      = 0;
  int send_idle_pct  = 0;
  int stall_pct      = 0;
  int hold_req       = 0;
  int hold_ack       = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;

  key_histogram_top_five i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #4 clk = ~clk;

  function automatic logic [CNT_W-1:0] bump_count(input logic [CNT_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  task automatic predict_item(input logic cmd, input logic [15:0] etype,
                              input logic [31:0] evalue, input logic [15:0] kcode);
    logic [NUM_KEYS-1:0] taken;
    int                  best;
    report_row_t         row;
    if (cmd == CMD_EVENT) begin
      if (etype == key_type_sel && evalue == '0 && kcode < NUM_KEYS) begin
        key_hits[kcode[KEY_W-1:0]] = bump_count(key_hits[kcode[KEY_W-1:0]]);
        release_total              = bump_count(release_total);
      end
    end else begin
      taken = '0;
      for (int r = 0; r < N_OUT; r++) begin
        best = -1;
        for (int k = 0; k < NUM_KEYS; k++)
          if (!taken[KEY_W'(k)] &&
              (best < 0 || key_hits[KEY_W'(k)] > key_hits[KEY_W'(best)])) best = k;
        taken[KEY_W'(best)] = 1'b1;
        row.rank          = RANK_W'(r);
        row.key           = KEY_W'(best);
        row.key_count     = key_hits[KEY_W'(best)];
        row.total_count   = release_total;
        row.watched_count = (watched_sel < NUM_KEYS) ? key_hits[watched_sel] : '0;
        row.last          = (r == N_OUT - 1);
        report_rows_q.push_back(row);
      end
    end
  endtask

  task automatic send_item(input logic cmd, input logic [15:0] etype,
                           input logic [31:0] evalue, input logic [15:0] kcode);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {kcode, evalue, etype};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_item(cmd, etype, evalue, kcode);
  endtask

  task automatic send_release(input logic [15:0] kcode);
    send_item(CMD_EVENT, key_type_sel, 32'h0, kcode);
  endtask

  task automatic send_report();
    send_item(CMD_REPORT, 16'($urandom), 32'($urandom), 16'($urandom));
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (report_rows_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic addr, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (addr == CFG_KEY_EVENT_TYPE) key_type_sel = value;
    else watched_sel = value[7:0];
    @(posedge clk);
  endtask

  task automatic send_random_item();
    int          pick;
    logic [15:0] etype;
    logic [31:0] evalue;
    logic [15:0] kcode;
    pick = $urandom_range(99);
    if (pick < 5) begin
      send_report();
    end else if (pick < 80) begin
      kcode = $urandom_range(1) ? 16'($urandom_range(15)) : 16'($urandom_range(NUM_KEYS - 1));
      send_release(kcode);
    end else begin
      etype  = key_type_sel;
      evalue = '0;
      kcode  = 16'($urandom_range(NUM_KEYS - 1));
      case ($urandom_range(3))
        0: evalue = $urandom;
        1: kcode  = 16'($urandom_range(16'hffff, NUM_KEYS));
        2: etype  = key_type_sel ^ 16'($urandom_range(16'hffff, 1));
        default: begin
          etype  = 16'($urandom);
          evalue = $urandom_range(1) ? 32'h0 : $urandom;
          kcode  = 16'($urandom);
        end
      endcase
      send_item(CMD_EVENT, etype, evalue, kcode);
    end
  endtask

  task automatic note_failure(input string msg);
    err_count++;
    if (err_count <= 10) $display("%s", msg);
  endtask

  task automatic check_field(input string what, input logic [CNT_W-1:0] want,
                             input logic [CNT_W-1:0] got);
    if (got !== want)
      note_failure($sformatf("mismatch %s: expected %0h actual %0h", what, want, got));
  endtask

  always @(posedge clk) begin : result_check
    report_row_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (report_rows_q.size() == 0) begin
        note_failure($sformatf("unexpected transfer: tdata %h tlast %b", out_tdata, out_tlast));
      end else begin
        want = report_rows_q.pop_front();
        check_field("rank",          CNT_W'(want.rank), CNT_W'(out_tdata[2:0]));
        check_field("reported_key",  CNT_W'(want.key),  CNT_W'(out_tdata[10:3]));
        check_field("key_count",     want.key_count,     out_tdata[42:11]);
        check_field("total_count",   want.total_count,   out_tdata[74:43]);
        check_field("watched_count", want.watched_count, out_tdata[106:75]);
        check_field("last",          CNT_W'(want.last),  CNT_W'(out_tlast));
      end
    end
    if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic test_directed_counting();
    send_idle_pct = 0;
    stall_pct     = 0;
    send_report();                                   // all zero: ties go to lowest codes
    send_release(16'd0);
    send_release(16'd255);
    send_release(16'd255);
    send_item(CMD_EVENT, key_type_sel, 32'h0, 16'd256);
    send_item(CMD_EVENT, key_type_sel, 32'h0, 16'hffff);
    send_item(CMD_EVENT, key_type_sel, 32'h1, 16'd7);
    send_item(CMD_EVENT, key_type_sel, 32'hffffffff, 16'd7);
    send_item(CMD_EVENT, key_type_sel, 32'h80000000, 16'd7);
    send_item(CMD_EVENT, key_type_sel, 32'h7fffffff, 16'd7);
    send_item(CMD_EVENT, 16'h0000, 32'h0, 16'd7);
    send_item(CMD_EVENT, 16'hffff, 32'h0, 16'd7);
    send_release(16'd56);
    send_release(16'd3);
    send_item(CMD_REPORT, 16'hffff, 32'hffffffff, 16'hffff);
    send_item(CMD_REPORT, 16'h0000, 32'h0, 16'h0000); // counters kept across reports
    send_release(16'd200);
    send_release(16'd200);
    send_report();
    wait_idle();
  endtask

  task automatic test_config_settings();
    write_reg(CFG_KEY_EVENT_TYPE, 16'h0000);
    write_reg(CFG_WATCHED_KEY, 16'd0);
    send_item(CMD_EVENT, 16'h0001, 32'h0, 16'd0);
    send_release(16'd0);
    send_release(16'd9);
    send_report();
    wait_idle();
    write_reg(CFG_KEY_EVENT_TYPE, 16'hffff);
    write_reg(CFG_WATCHED_KEY, 16'hff);
    send_release(16'd255);
    send_item(CMD_EVENT, 16'h0000, 32'h0, 16'd255);
    send_report();
    wait_idle();
  endtask

  task automatic test_random_phase(input int idle_pct, input int hold_pct, input int n_items);
    logic [15:0] type_val;
    logic [15:0] watch_val;
    wait_idle();
    case ($urandom_range(3))
      0: type_val = 16'h0000;
      1: type_val = 16'hffff;
      2: type_val = 16'h0001;
      default: type_val = 16'($urandom);
    endcase
    case ($urandom_range(2))
      0: watch_val = 16'd0;
      1: watch_val = 16'd255;
      default: watch_val = 16'($urandom);
    endcase
    write_reg(CFG_KEY_EVENT_TYPE, type_val);
    write_reg(CFG_WATCHED_KEY, watch_val);
    send_idle_pct = idle_pct;
    stall_pct     = hold_pct;
    repeat (n_items) send_random_item();
    send_report();
  endtask

  task automatic test_receiver_holdoff();
    wait_idle();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req++;
    send_report();
    repeat (12) send_release(16'($urandom_range(31)));
    send_report();
    repeat (6) send_release(16'($urandom_range(31)));
  endtask

  task automatic test_sender_pause();
    send_idle_pct = 14;
    stall_pct     = 14;
    repeat (8) send_random_item();
    send_report();
    wait_idle();
    repeat (8) send_random_item();
    send_report();
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = CMD_EVENT;
    out_tready = 1'b0;
    cfg_we     = 1'b0;
    cfg_addr   = CFG_KEY_EVENT_TYPE;
    cfg_wdata  = '0;
    for (int k = 0; k < NUM_KEYS; k++) key_hits[KEY_W'(k)] = '0;
    release_total = '0;
    key_type_sel  = 16'd1;
    watched_sel   = 8'd56;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_counting();
    test_config_settings();
    test_random_phase(0, 0, 95);
    test_random_phase(47, 0, 85);
    test_random_phase(0, 47, 85);
    test_random_phase(14, 14, 85);
    test_receiver_holdoff();
    test_sender_pause();

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

/* filelist.f */
sv/khtf_pkg.sv
sv/khtf_ram.sv
sv/khtf_sel.sv
sv/key_histogram_top_five.sv
verif/tb_top.sv
